@@ design/rc4_pkg.sv @@
// ---------------------------------------------------------------------------
// rc4_pkg
// Shared widths, constants and types of the rc4 keystream generator.
// ---------------------------------------------------------------------------
package rc4_pkg;

	localparam int BYTE_W       = 8;
	localparam int TABLE_DEPTH  = 256;
	localparam int FIELD_COUNT  = 5;
	localparam int RESULT_LIMIT = 8;
	localparam int RES_CNT_W    = $clog2(RESULT_LIMIT);

	typedef logic [BYTE_W-1:0] byte_t;

	// key bytes, entry 0 is the first byte of the seed
	typedef logic [FIELD_COUNT-1:0][BYTE_W-1:0] key_t;

	// one keystream word from the engine toward the output register
	typedef struct packed {
		logic  valid;
		byte_t data;
		logic  last;
	} res_t;

endpackage

@@ design/rc4_stream_if.sv @@
// ---------------------------------------------------------------------------
// rc4_key_if / rc4_byte_if
// Valid/ready channels of the rc4 keystream generator: key in, bytes out.
// ---------------------------------------------------------------------------
interface rc4_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte0;
	logic [7:0] key_byte1;
	logic [7:0] key_byte2;
	logic [7:0] key_byte3;
	logic [7:0] key_byte4;

	modport source (
		output valid, key_byte0, key_byte1, key_byte2, key_byte3, key_byte4,
		input  ready
	);
	modport sink (
		input  valid, key_byte0, key_byte1, key_byte2, key_byte3, key_byte4,
		output ready
	);
endinterface

interface rc4_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       last_byte;

	modport source (
		output valid, stream_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, stream_byte, last_byte,
		output ready
	);
endinterface

@@ design/rc4_ram.sv @@
// ---------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ---------------------------------------------------------------------------
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/rc4_engine.sv @@
// ---------------------------------------------------------------------------
// rc4_engine
// Permutation table in one RAM plus the sequencer that fills it, runs the
// key schedule and the output rounds as read-modify-write swaps.
// ---------------------------------------------------------------------------
module rc4_engine #(
	parameter int KEY_BYTES = 5,
	parameter int OUT_BYTES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rc4_pkg::key_t key,
	output logic          busy,
	output rc4_pkg::res_t res,
	input  logic          res_ready
);
	import rc4_pkg::*;

	localparam int KW   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int NOUT = (OUT_BYTES > RESULT_LIMIT) ? RESULT_LIMIT : OUT_BYTES;
	localparam int AW   = $clog2(TABLE_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FILL = 4'd1;
	localparam logic [3:0] ST_K_RJ = 4'd2;
	localparam logic [3:0] ST_K_WJ = 4'd3;
	localparam logic [3:0] ST_K_WI = 4'd4;
	localparam logic [3:0] ST_G_RJ = 4'd5;
	localparam logic [3:0] ST_G_WJ = 4'd6;
	localparam logic [3:0] ST_G_WI = 4'd7;
	localparam logic [3:0] ST_G_RT = 4'd8;
	localparam logic [3:0] ST_G_OUT = 4'd9;

	logic [3:0]           state_q;
	logic [AW-1:0]        a_q;
	logic [AW-1:0]        j_q;
	logic [KW-1:0]        kidx_q;
	logic [RES_CNT_W-1:0] n_q;
	byte_t                si_q;
	byte_t                sj_q;
	key_t                 key_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	byte_t         wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	byte_t         rd_data;

	logic [4:0]    kx;
	byte_t         key_sel;
	logic [AW-1:0] j_next;
	logic          last_res;
	logic          res_go;

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_DEPTH)
	) u_perm (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// key positions beyond the five fields read as zero
	assign kx      = 5'(kidx_q);
	assign key_sel = (kx < 5'(FIELD_COUNT)) ? key_q[kx[2:0]] : '0;

	assign j_next   = (state_q == ST_K_RJ) ? AW'(j_q + rd_data + key_sel)
	                                       : AW'(j_q + rd_data);
	assign last_res = (n_q == RES_CNT_W'(NOUT - 1));
	assign res_go   = (state_q == ST_G_OUT) && res_ready;

	assign busy      = (state_q != ST_IDLE);
	assign res.valid = (state_q == ST_G_OUT);
	assign res.data  = rd_data;
	assign res.last  = last_res;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = a_q;
		wr_data = sj_q;
		rd_en   = 1'b0;
		rd_addr = AW'(a_q + 1'b1);
		unique case (state_q)
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = a_q;
				// last fill write: fetch entry 0 for the first schedule step
				rd_en   = (a_q == AW'(TABLE_DEPTH - 1));
			end
			ST_K_RJ, ST_G_RJ: begin
				rd_en   = 1'b1;
				rd_addr = j_next;
			end
			ST_K_WJ, ST_G_WJ: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			ST_K_WI: begin
				wr_en = 1'b1;
				rd_en = 1'b1;
				// last schedule step: fetch entry 1 for the first output round
				if (a_q == AW'(TABLE_DEPTH - 1)) begin
					rd_addr = AW'(1);
				end
			end
			ST_G_WI: begin
				wr_en = 1'b1;
			end
			ST_G_RT: begin
				rd_en   = 1'b1;
				rd_addr = AW'(si_q + sj_q);
			end
			ST_G_OUT: begin
				rd_en = res_go && !last_res;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		if (state_q == ST_K_RJ || state_q == ST_G_RJ) begin
			si_q <= rd_data;
		end
		if (state_q == ST_K_WJ || state_q == ST_G_WJ) begin
			sj_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			j_q     <= '0;
			kidx_q  <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FILL;
						a_q     <= '0;
					end
				end
				ST_FILL: begin
					a_q <= AW'(a_q + 1'b1);
					if (a_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_K_RJ;
						j_q     <= '0;
						kidx_q  <= '0;
					end
				end
				ST_K_RJ: begin
					j_q     <= j_next;
					state_q <= ST_K_WJ;
				end
				ST_K_WJ: begin
					state_q <= ST_K_WI;
				end
				ST_K_WI: begin
					if (kidx_q == KW'(KEY_BYTES - 1)) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= KW'(kidx_q + 1'b1);
					end
					if (a_q == AW'(TABLE_DEPTH - 1)) begin
						// schedule done, entry 1 is being read for the first round
						a_q     <= AW'(1);
						j_q     <= '0;
						n_q     <= '0;
						state_q <= ST_G_RJ;
					end else begin
						a_q     <= AW'(a_q + 1'b1);
						state_q <= ST_K_RJ;
					end
				end
				ST_G_RJ: begin
					j_q     <= j_next;
					state_q <= ST_G_WJ;
				end
				ST_G_WJ: begin
					state_q <= ST_G_WI;
				end
				ST_G_WI: begin
					state_q <= ST_G_RT;
				end
				ST_G_RT: begin
					state_q <= ST_G_OUT;
				end
				ST_G_OUT: begin
					if (res_go) begin
						if (last_res) begin
							state_q <= ST_IDLE;
						end else begin
							n_q     <= RES_CNT_W'(n_q + 1'b1);
							a_q     <= AW'(a_q + 1'b1);
							state_q <= ST_G_RJ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("engine started while busy");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res_ready |=> res.valid && $stable(res.data) && $stable(res.last))
		else $error("stalled keystream word changed");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res_ready && res.last |=> state_q == ST_IDLE)
		else $error("engine kept running after last word");

	a_fill_to_ksa: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL && a_q == AW'(TABLE_DEPTH - 1) |=> state_q == ST_K_RJ && a_q == '0)
		else $error("fill did not hand over to key schedule");

endmodule

@@ design/rc4_keystream_generator.sv @@
// ---------------------------------------------------------------------------
// rc4_keystream_generator
// RC4 keystream from a short key: table fill, key schedule, output rounds.
// ---------------------------------------------------------------------------
// key: valid/ready channel carrying five key bytes. A word is taken only
//   while the block is idle; key.ready drops for the whole run.
// stream: valid/ready channel of keystream bytes, one word per byte, in
//   generation order; last_byte marks the final byte of a run.
// Each run writes the 256-entry table to identity, then runs the key schedule
// (read j, write j, write i per entry), then the output rounds (read j, write
// j, write i, read the output entry, hand out the byte). The table sits in one
// RAM with a single write port, so each swap is done as two separate writes.
// The last byte waits in the output register, so the next key is taken while
// it is still pending.
// If the receiver stalls, the engine holds its current byte and stops until
// the output register drains; nothing is lost.
// Reset clears the sequencer and output valid; the table is rebuilt by every
// run and needs no clearing.
// ---------------------------------------------------------------------------
module rc4_keystream_generator #(
	parameter int KEY_BYTES = 5,
	parameter int OUT_BYTES = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	rc4_key_if.sink    key,
	rc4_byte_if.source stream
);
	import rc4_pkg::*;

	logic  start;
	logic  busy;
	key_t  key_word;
	res_t  res;
	logic  res_ready;
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	assign key.ready = !busy;
	assign start     = key.valid && !busy;

	assign key_word[0] = key.key_byte0;
	assign key_word[1] = key.key_byte1;
	assign key_word[2] = key.key_byte2;
	assign key_word[3] = key.key_byte3;
	assign key_word[4] = key.key_byte4;

	rc4_engine #(
		.KEY_BYTES (KEY_BYTES),
		.OUT_BYTES (OUT_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.key       (key_word),
		.busy      (busy),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register takes a new word when empty or draining
	assign res_ready = !out_valid_q || stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_byte_q <= res.data;
			out_last_q <= res.last;
		end
	end

	assign stream.valid       = out_valid_q;
	assign stream.stream_byte = out_byte_q;
	assign stream.last_byte   = out_last_q;

endmodule
